### hw/rtl/cvcb_pkg.sv
// ----------------------------------------------------------------------------
// cvcb_pkg: shared types and constants of the CAN voltage command bridge
// Beat layouts, register map codes and fixed identifiers.
// ----------------------------------------------------------------------------
`default_nettype none

package cvcb_pkg;

  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIndexWidth = 3;

  // Register map, byte address = 4 * index
  localparam logic [CfgIndexWidth-1:0] REG_BRIDGE_ENABLE      = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_NODE_NUMBER        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_COMMAND_TIMEOUT    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_FEEDBACK_PERIOD    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_COMMAND_MV     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_DIRECTION_NEGATIVE = 3'd5;

  localparam logic        CMD_FRAME = 1'b0;
  localparam logic        CMD_TICK  = 1'b1;

  localparam logic [28:0] GROUP_LOW_ID  = 29'h100;
  localparam logic [28:0] GROUP_HIGH_ID = 29'h200;
  localparam logic [10:0] FEEDBACK_BASE = 11'h100;
  localparam logic [3:0]  FRAME_FULL_BYTES = 4'd8;

  // 0.3/pi scaled by 2^32: mrad/s to rpm x10
  localparam logic [28:0] SPEED_K = 29'd410139165;

  localparam logic [3:0]  NODE_NUMBER_RESET = 4'd1;
  localparam logic [31:0] TIMEOUT_RESET     = 32'd100000;
  localparam logic [31:0] PERIOD_RESET      = 32'd2000;
  localparam logic [14:0] MAX_MV_RESET      = 15'd3000;

  typedef struct packed {
    logic               command;
    logic [28:0]        frame_id;
    logic               frame_standard;
    logic [3:0]         frame_bytes;
    logic [63:0]        frame_data;
    logic [31:0]        now_us;
    logic signed [31:0] sensor_angle;
    logic signed [31:0] speed_mrad_per_s;
  } item_t;

  typedef struct packed {
    logic               frame_accepted;
    logic               drive_enable;
    logic signed [15:0] drive_mv;
    logic               timeout_event;
    logic               feedback_valid;
    logic [10:0]        feedback_id;
    logic [63:0]        feedback_data;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/can_voltage_command_bridge_top.sv
// ----------------------------------------------------------------------------
// can_voltage_command_bridge_top: CAN voltage command bridge
// Takes received frames and run ticks, keeps the voltage command and the
// watchdog, and builds feedback frames with angle and scaled speed.
// ----------------------------------------------------------------------------
//
//  channel   handshake                     beat      width
//  --------  ----------------------------  --------  ---------------------
//  item      item_valid / item_stall       item      item_t (195 bits)
//  result    result_valid / result_stall   result    result_t (95 bits)
//  config    APB psel/penable/pwrite       pwdata    32 bits, paddr 5 bits
//
//  One beat in per cycle while item_stall is low, one result beat out per
//  item, passing an input register, then one pass of compare, clamp and a
//  single 32x29 speed multiply into the result register.
//  The only loop is the state update at the input register's output, so
//  items follow back to back.
//  rst is synchronous and active high; it clears control state and loads
//  the register reset values.
//  A stall on the result side holds the result register and backs up into
//  the input register; item_stall rises only when that register is full.
//
`default_nettype none

module can_voltage_command_bridge_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire cvcb_pkg::item_t                     item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output cvcb_pkg::result_t                        result,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cvcb_pkg::CfgAddrWidth-1:0]   paddr,
  input  wire logic [cvcb_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [cvcb_pkg::CfgDataWidth-1:0]        prdata,
  output logic                                     pready
);

  import cvcb_pkg::*;

  // Configuration registers
  logic        bridge_enable;
  logic [3:0]  node_number;
  logic [31:0] command_timeout_us;
  logic [31:0] feedback_period_us;
  logic [14:0] max_command_mv;
  logic        direction_negative;

  logic [CfgIndexWidth-1:0] cfg_index;
  logic                     cfg_write;

  assign pready    = 1'b1;
  assign cfg_index = paddr[CfgAddrWidth-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bridge_enable      <= 1'b0;
      node_number        <= NODE_NUMBER_RESET;
      command_timeout_us <= TIMEOUT_RESET;
      feedback_period_us <= PERIOD_RESET;
      max_command_mv     <= MAX_MV_RESET;
      direction_negative <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BRIDGE_ENABLE:      bridge_enable      <= pwdata[0];
        REG_NODE_NUMBER:        node_number        <= pwdata[3:0];
        REG_COMMAND_TIMEOUT:    command_timeout_us <= pwdata;
        REG_FEEDBACK_PERIOD:    feedback_period_us <= pwdata;
        REG_MAX_COMMAND_MV:     max_command_mv     <= pwdata[14:0];
        REG_DIRECTION_NEGATIVE: direction_negative <= pwdata[0];
        default: ;  // drop writes past the register map
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_BRIDGE_ENABLE:      prdata = {31'd0, bridge_enable};
      REG_NODE_NUMBER:        prdata = {28'd0, node_number};
      REG_COMMAND_TIMEOUT:    prdata = command_timeout_us;
      REG_FEEDBACK_PERIOD:    prdata = feedback_period_us;
      REG_MAX_COMMAND_MV:     prdata = {17'd0, max_command_mv};
      REG_DIRECTION_NEGATIVE: prdata = {31'd0, direction_negative};
      default:                prdata = '0;
    endcase
  end

  // Input register and flow control
  logic  in_valid;
  item_t in_item;
  logic  advance;
  logic  out_free;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_valid && out_free;
  assign item_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      in_item <= item;
    end
  end

  // Bridge state
  logic signed [15:0] command_mv, command_mv_next;
  logic [31:0]        last_command_time, last_command_time_next;
  logic [31:0]        last_feedback_time, last_feedback_time_next;
  logic               voltage_mode_active, voltage_mode_active_next;

  // Frame decode: drives 1-4 listen on the low group, 5-8 on the high one;
  // the slot is (node_number - 1) mod 4 in both cases.
  logic               frame_ok;
  logic               group_low, group_high;
  logic               frame_hit;
  logic [3:0]         node_number_less1;
  logic [1:0]         slot;
  logic signed [15:0] raw_mv;
  logic signed [16:0] lim_pos, lim_neg;
  logic signed [15:0] clamped_mv;

  assign frame_ok       = in_item.frame_standard && (in_item.frame_bytes == FRAME_FULL_BYTES);
  assign group_low      = (node_number >= 4'd1) && (node_number <= 4'd4)
                          && (in_item.frame_id == GROUP_LOW_ID);
  assign group_high     = (node_number >= 4'd5) && (node_number <= 4'd8)
                          && (in_item.frame_id == GROUP_HIGH_ID);
  assign frame_hit      = frame_ok && (group_low || group_high);
  assign node_number_less1 = node_number - 4'd1;
  assign slot           = node_number_less1[1:0];
  assign raw_mv         = in_item.frame_data[{slot, 4'd0} +: 16];
  assign lim_pos        = $signed({2'b00, max_command_mv});
  assign lim_neg        = -lim_pos;

  always_comb begin
    if (17'(raw_mv) > lim_pos) begin
      clamped_mv = lim_pos[15:0];
    end else if (17'(raw_mv) < lim_neg) begin
      clamped_mv = lim_neg[15:0];
    end else begin
      clamped_mv = raw_mv;
    end
  end

  // Tick timing, all differences modulo 2^32
  logic [31:0] since_command, since_feedback;
  logic        watchdog_trip, feedback_due;

  assign since_command  = in_item.now_us - last_command_time;
  assign since_feedback = in_item.now_us - last_feedback_time;
  assign watchdog_trip  = since_command > command_timeout_us;
  assign feedback_due   = since_feedback >= feedback_period_us;

  // Feedback payload: direction-signed angle, saturated only at +2^31
  logic signed [32:0] angle_dir;
  logic [31:0]        angle_field;
  logic signed [32:0] speed_dir;
  logic               speed_neg;
  logic signed [32:0] speed_abs;
  logic [31:0]        speed_mag;
  logic [60:0]        speed_prod;
  logic [28:0]        speed_q;
  logic [28:0]        speed_q_neg;
  logic [15:0]        speed_field;

  assign angle_dir   = direction_negative ? -33'(in_item.sensor_angle)
                                          : 33'(in_item.sensor_angle);
  assign angle_field = (angle_dir > 33'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF : angle_dir[31:0];

  assign speed_dir  = direction_negative ? -33'(in_item.speed_mrad_per_s)
                                         : 33'(in_item.speed_mrad_per_s);
  assign speed_neg  = speed_dir[32];
  assign speed_abs  = speed_neg ? -speed_dir : speed_dir;
  assign speed_mag  = speed_abs[31:0];
  assign speed_prod = 61'(speed_mag) * 61'(SPEED_K);
  assign speed_q    = speed_prod[60:32];
  assign speed_q_neg = -speed_q;

  always_comb begin
    if (speed_neg) begin
      speed_field = (speed_q > 29'd32768) ? 16'h8000 : speed_q_neg[15:0];
    end else begin
      speed_field = (speed_q > 29'd32767) ? 16'h7FFF : speed_q[15:0];
    end
  end

  // State update and result for the item leaving the input register
  result_t outcome;

  always_comb begin
    command_mv_next          = command_mv;
    last_command_time_next   = last_command_time;
    last_feedback_time_next  = last_feedback_time;
    voltage_mode_active_next = voltage_mode_active;
    outcome                  = '0;

    if (bridge_enable) begin
      if (in_item.command == CMD_FRAME) begin
        if (frame_hit) begin
          command_mv_next          = clamped_mv;
          last_command_time_next   = in_item.now_us;
          voltage_mode_active_next = 1'b1;
          outcome.frame_accepted   = 1'b1;
        end
      end else begin
        if (voltage_mode_active) begin
          if (watchdog_trip) begin
            // drop voltage mode and zero the command
            command_mv_next          = '0;
            voltage_mode_active_next = 1'b0;
            outcome.timeout_event    = 1'b1;
          end else begin
            outcome.drive_enable = 1'b1;
          end
        end
        if (feedback_due) begin
          last_feedback_time_next = in_item.now_us;
          outcome.feedback_valid  = 1'b1;
          outcome.feedback_id     = FEEDBACK_BASE + 11'(node_number);
          outcome.feedback_data   = {16'd0, speed_field, angle_field};
        end
      end
    end

    outcome.drive_mv = command_mv_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_mv          <= '0;
      last_command_time   <= '0;
      last_feedback_time  <= '0;
      voltage_mode_active <= 1'b0;
    end else if (advance) begin
      command_mv          <= command_mv_next;
      last_command_time   <= last_command_time_next;
      last_feedback_time  <= last_feedback_time_next;
      voltage_mode_active <= voltage_mode_active_next;
    end
  end

  // Result register: load on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= outcome;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cvcb_checker.sv
// ----------------------------------------------------------------------------
// cvcb_checker: port-level checks of the CAN voltage command bridge
// Watches the result channel and ties field groups together.
// ----------------------------------------------------------------------------
`default_nettype none

module cvcb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire cvcb_pkg::result_t result
);

  import cvcb_pkg::*;

  // hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // a frame beat carries no tick outcome
  a_frame_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_accepted
      |-> !result.drive_enable && !result.timeout_event && !result.feedback_valid)
    else $error("frame result mixed with tick outcome");

  // a watchdog trip zeroes the command and does not drive
  a_trip_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.timeout_event
      |-> result.drive_mv == 16'sd0 && !result.drive_enable)
    else $error("watchdog trip left a command");

  // no feedback beat means empty feedback fields
  a_feedback_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.feedback_valid
      |-> result.feedback_id == 11'd0 && result.feedback_data == 64'd0)
    else $error("feedback fields set without feedback");

endmodule

bind can_voltage_command_bridge_top cvcb_checker u_cvcb_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the CAN voltage command bridge
// Drives received frames and run ticks under random idling and back-pressure,
// predicts every result beat in step with each accepted beat, and compares
// the beats field by field while the register settings move through their
// extremes.
// ----------------------------------------------------------------------------

module testbench;
  import cvcb_pkg::*;

  localparam int          DRAIN_CYCLES = 6;     // two-stage pipe plus margin
  localparam int          STUCK_LIMIT  = 1000;
  localparam int          LONG_HOLD    = 150;
  localparam int          NUM_PHASES   = 11;
  localparam logic [63:0] SPEED_SCALE  = 64'd410139165;  // 0.3/pi * 2^32

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  item_t                     item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_t                   result;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CfgAddrWidth-1:0]   paddr = '0;
  logic [CfgDataWidth-1:0]   pwdata = '0;
  logic [CfgDataWidth-1:0]   prdata;
  logic                      pready;

  can_voltage_command_bridge_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bridge predictor: own copy of the registers and of the command state
  // --------------------------------------------------------------------------
  logic               cfg_enable;
  logic [3:0]         cfg_drive;
  logic [31:0]        cfg_timeout;
  logic [31:0]        cfg_period;
  logic [14:0]        cfg_limit;
  logic               cfg_reverse;

  logic signed [15:0] held_mv;
  logic [31:0]        cmd_stamp;
  logic [31:0]        feedback_stamp;
  logic               voltage_mode;

  // Run statistics for the summary
  int n_items = 0;
  int n_results = 0;
  int n_taken = 0;
  int n_trips = 0;
  int n_feedback = 0;
  int n_settings = 0;
  int mismatches = 0;

  task automatic reset_bridge_model();
    cfg_enable     = 1'b0;
    cfg_drive      = NODE_NUMBER_RESET;
    cfg_timeout    = TIMEOUT_RESET;
    cfg_period     = PERIOD_RESET;
    cfg_limit      = MAX_MV_RESET;
    cfg_reverse    = 1'b0;
    held_mv        = '0;
    cmd_stamp      = '0;
    feedback_stamp = '0;
    voltage_mode   = 1'b0;
  endtask

  task automatic apply_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_BRIDGE_ENABLE:      cfg_enable  = val[0];
      REG_NODE_NUMBER:        cfg_drive   = val[3:0];
      REG_COMMAND_TIMEOUT:    cfg_timeout = val;
      REG_FEEDBACK_PERIOD:    cfg_period  = val;
      REG_MAX_COMMAND_MV:     cfg_limit   = val[14:0];
      REG_DIRECTION_NEGATIVE: cfg_reverse = val[0];
      default: ;
    endcase
  endtask

  // Work out the result beat of one accepted item and advance the state.
  function automatic result_t predict_bridge(input item_t it);
    result_t     r;
    logic        hit;
    int          slot;
    logic [15:0] raw;
    int          mv;
    int          lim;
    logic [31:0] elapsed;
    longint      ang;
    longint      spd;
    logic [63:0] mag;
    logic [63:0] q;
    logic [15:0] spd_word;
    r = '0;
    if (cfg_enable) begin
      if (it.command == CMD_FRAME) begin
        if (it.frame_standard && it.frame_bytes == FRAME_FULL_BYTES) begin
          hit  = 1'b0;
          slot = 0;
          if (cfg_drive >= 1 && cfg_drive <= 4 && it.frame_id == GROUP_LOW_ID) begin
            hit  = 1'b1;
            slot = cfg_drive - 1;
          end else if (cfg_drive >= 5 && cfg_drive <= 8 && it.frame_id == GROUP_HIGH_ID) begin
            hit  = 1'b1;
            slot = cfg_drive - 5;
          end
          if (hit) begin
            raw = it.frame_data[slot*16 +: 16];
            mv  = $signed(raw);
            lim = int'(cfg_limit);
            if (mv > lim) mv = lim;
            if (mv < -lim) mv = -lim;
            held_mv      = 16'(mv);
            cmd_stamp    = it.now_us;
            voltage_mode = 1'b1;
            r.frame_accepted = 1'b1;
            n_taken++;
          end
        end
      end else begin
        if (voltage_mode) begin
          elapsed = it.now_us - cmd_stamp;
          if (elapsed > cfg_timeout) begin
            held_mv         = '0;
            voltage_mode    = 1'b0;
            r.timeout_event = 1'b1;
            n_trips++;
          end else begin
            r.drive_enable = 1'b1;
          end
        end
        elapsed = it.now_us - feedback_stamp;
        if (elapsed >= cfg_period) begin
          ang = longint'($signed(it.sensor_angle));
          spd = longint'($signed(it.speed_mrad_per_s));
          if (cfg_reverse) begin
            ang = -ang;
            spd = -spd;
          end
          if (ang > 64'sd2147483647) ang = 64'sd2147483647;
          mag = (spd < 0) ? 64'(-spd) : 64'(spd);
          q   = (mag * SPEED_SCALE) >> 32;
          if (spd < 0) begin
            spd_word = (q > 32768) ? 16'h8000 : 16'(-q);
          end else begin
            spd_word = (q > 32767) ? 16'h7FFF : q[15:0];
          end
          feedback_stamp   = it.now_us;
          r.feedback_valid = 1'b1;
          r.feedback_id    = 11'(FEEDBACK_BASE + cfg_drive);
          r.feedback_data  = {16'h0000, spd_word, ang[31:0]};
          n_feedback++;
        end
      end
    end
    r.drive_mv = held_mv;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Beat builders; fields that the item kind ignores get random bits
  // --------------------------------------------------------------------------
  function automatic item_t frame_beat(input logic [28:0] id, input logic std,
                                       input logic [3:0] nbytes, input logic [63:0] data,
                                       input logic [31:0] now);
    item_t it;
    it.command          = CMD_FRAME;
    it.frame_id         = id;
    it.frame_standard   = std;
    it.frame_bytes      = nbytes;
    it.frame_data       = data;
    it.now_us           = now;
    it.sensor_angle     = $urandom();
    it.speed_mrad_per_s = $urandom();
    return it;
  endfunction

  function automatic item_t tick_beat(input logic [31:0] now, input logic [31:0] ang,
                                      input logic [31:0] spd);
    item_t it;
    it.command          = CMD_TICK;
    it.frame_id         = 29'($urandom());
    it.frame_standard   = 1'($urandom());
    it.frame_bytes      = 4'($urandom_range(0, 8));
    it.frame_data       = {$urandom(), $urandom()};
    it.now_us           = now;
    it.sensor_angle     = ang;
    it.speed_mrad_per_s = spd;
    return it;
  endfunction

  // Random payload with one millivolt slot forced to a chosen value
  function automatic logic [63:0] with_slot(input int slot, input logic [15:0] mv);
    logic [63:0] data;
    data = {$urandom(), $urandom()};
    data[slot*16 +: 16] = mv;
    return data;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  logic [31:0] t_now = '0;
  int          step_max = 50;

  function automatic logic [31:0] sensor_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4, 5: return 32'($signed($urandom_range(0, 800000)) - 400000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] slot_word();
    int lim;
    lim = int'(cfg_limit);
    case ($urandom_range(0, 9))
      0:       return 16'(lim);
      1:       return 16'(lim + 1);
      2:       return 16'(-lim);
      3:       return 16'(-lim - 1);
      4:       return 16'h7FFF;
      5:       return 16'h8000;
      6:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] span_word(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic item_t random_beat();
    logic [28:0] own_id;
    logic [28:0] other_id;
    logic [31:0] now;
    int          slot;
    // advance the time base, with rare jumps that cross the wrap
    if ($urandom_range(0, 49) == 0) t_now = t_now + $urandom();
    else t_now = t_now + $urandom_range(0, step_max);
    now = ($urandom_range(0, 39) == 0) ? $urandom() : t_now;
    if ($urandom_range(0, 99) < 55) begin
      return tick_beat(now, sensor_word(), sensor_word());
    end
    own_id   = (cfg_drive >= 5 && cfg_drive <= 8) ? GROUP_HIGH_ID : GROUP_LOW_ID;
    other_id = (own_id == GROUP_LOW_ID) ? GROUP_HIGH_ID : GROUP_LOW_ID;
    slot     = (cfg_drive - 1) & 3;
    case ($urandom_range(0, 9))
      7:       return frame_beat(other_id, 1'b1, FRAME_FULL_BYTES,
                                 with_slot(slot, slot_word()), now);
      8:       return frame_beat(own_id, 1'b0, FRAME_FULL_BYTES,
                                 with_slot(slot, slot_word()), now);
      9:       return frame_beat($urandom_range(0, 1) ? 29'($urandom()) : own_id,
                                 1'($urandom()), 4'($urandom_range(0, 7)),
                                 with_slot(slot, slot_word()), now);
      default: return frame_beat(own_id, 1'b1, FRAME_FULL_BYTES,
                                 with_slot(slot, slot_word()), now);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Item driver: feeds beats from the pending queue, predicts on acceptance
  // --------------------------------------------------------------------------
  item_t   pending_q[$];
  result_t expected_q[$];
  logic    send_calm = 1'b0;
  logic    recv_calm = 1'b0;
  int      gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap        <= 0;
    end else begin
      // beat taken at this edge: its expected result goes in now
      if (item_valid && !item_stall) begin
        expected_q.push_back(predict_bridge(item));
        n_items++;
      end
      // hold a stalled beat; otherwise idle out the gap or advance
      if (!item_valid || !item_stall) begin
        if (gap != 0) begin
          item_valid <= 1'b0;
          gap        <= gap - 1;
        end else if (pending_q.size() != 0) begin
          item       <= pending_q.pop_front();
          item_valid <= 1'b1;
          gap        <= send_calm ? 0 : $urandom_range(0, 7);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each taken beat and drives random back-pressure
  // --------------------------------------------------------------------------
  int long_req = 0;
  int long_done = 0;
  int hold_left = 0;

  task automatic field_mismatch(input string name, input logic [63:0] want,
                                input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatches++;
  endtask

  task automatic compare_result(input result_t want, input result_t got);
    if (got.frame_accepted !== want.frame_accepted)
      field_mismatch("frame_accepted", 64'(want.frame_accepted), 64'(got.frame_accepted));
    if (got.drive_enable !== want.drive_enable)
      field_mismatch("drive_enable", 64'(want.drive_enable), 64'(got.drive_enable));
    if (got.drive_mv !== want.drive_mv)
      field_mismatch("drive_mv", 64'(want.drive_mv), 64'(got.drive_mv));
    if (got.timeout_event !== want.timeout_event)
      field_mismatch("timeout_event", 64'(want.timeout_event), 64'(got.timeout_event));
    if (got.feedback_valid !== want.feedback_valid)
      field_mismatch("feedback_valid", 64'(want.feedback_valid), 64'(got.feedback_valid));
    if (got.feedback_id !== want.feedback_id)
      field_mismatch("feedback_id", 64'(want.feedback_id), 64'(got.feedback_id));
    if (got.feedback_data !== want.feedback_data)
      field_mismatch("feedback_data", want.feedback_data, got.feedback_data);
  endtask

  always @(posedge clk) begin : result_side
    int w;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, result);
          mismatches++;
        end else begin
          compare_result(expected_q.pop_front(), result);
        end
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left    <= hold_left - 1;
      end else if (long_req != long_done) begin
        // long hold-off: let the pipe fill and push back on the sender
        long_done    <= long_done + 1;
        result_stall <= 1'b1;
        hold_left    <= LONG_HOLD;
      end else if (result_valid && !result_stall) begin
        w = recv_calm ? 0 : $urandom_range(0, 7);
        result_stall <= (w != 0);
        hold_left    <= (w == 0) ? 0 : w - 1;
      end else begin
        result_stall <= !recv_calm && ($urandom_range(0, 3) == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with work outstanding and no beat moving
  // --------------------------------------------------------------------------
  int stuck = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (pending_q.size() == 0 && !item_valid && expected_q.size() == 0)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic write_all(input logic en, input logic [3:0] drv, input logic [31:0] tmo,
                           input logic [31:0] per, input logic [14:0] lim, input logic rev);
    write_reg(REG_BRIDGE_ENABLE, 32'(en));
    write_reg(REG_NODE_NUMBER, 32'(drv));
    write_reg(REG_COMMAND_TIMEOUT, tmo);
    write_reg(REG_FEEDBACK_PERIOD, per);
    write_reg(REG_MAX_COMMAND_MV, 32'(lim));
    write_reg(REG_DIRECTION_NEGATIVE, 32'(rev));
    n_settings++;
    @(negedge clk);
  endtask

  // Wait out every outstanding beat, then the pipe latency.
  task automatic settle_idle();
    while (pending_q.size() != 0 || item_valid || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic        en;
    logic [3:0]  drv;
    logic [31:0] tmo;
    logic [31:0] per;
    logic [14:0] lim;
    logic        rev;
    int          count;
    reset_bridge_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bridge still disabled out of reset: both kinds are dropped.
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b1, FRAME_FULL_BYTES,
                                   with_slot(0, 16'd500), 32'd3));
    pending_q.push_back(tick_beat(32'd5000, 32'h1234_5678, 32'd1000));
    settle_idle();

    // Drive 3 at the low group, short watchdog and period.
    write_all(1'b1, 4'd3, 32'd100, 32'd10, MAX_MV_RESET, 1'b0);
    pending_q.push_back(tick_beat(32'd5, 32'd1, 32'd1));
    pending_q.push_back(tick_beat(32'd10, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b1, FRAME_FULL_BYTES,
                                   with_slot(2, 16'h7FFF), 32'd20));
    pending_q.push_back(tick_beat(32'd25, 32'd100, 32'd2000));
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b1, FRAME_FULL_BYTES,
                                   with_slot(2, 16'h8000), 32'd30));
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b0, FRAME_FULL_BYTES,
                                   with_slot(2, 16'd1234), 32'd32));
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b1, 4'd7,
                                   with_slot(2, 16'd1234), 32'd34));
    pending_q.push_back(frame_beat(GROUP_HIGH_ID, 1'b1, FRAME_FULL_BYTES,
                                   with_slot(2, 16'd1234), 32'd36));
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b1, FRAME_FULL_BYTES,
                                   with_slot(2, 16'hFFFB), 32'd40));
    pending_q.push_back(tick_beat(32'd140, 32'd7, 32'd7));   // exactly at the timeout
    pending_q.push_back(tick_beat(32'd141, 32'd7, 32'd7));   // one past: trips
    pending_q.push_back(tick_beat(32'd142, 32'd7, 32'd7));
    pending_q.push_back(tick_beat(32'd200, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(tick_beat(32'd300, 32'd0, -32'sd1000));
    settle_idle();

    // Drive 8, zero clamp, zero timeout and period, reversed sensor.
    write_all(1'b1, 4'd8, 32'd0, 32'd0, 15'd0, 1'b1);
    pending_q.push_back(frame_beat(GROUP_HIGH_ID, 1'b1, FRAME_FULL_BYTES,
                                   with_slot(3, 16'h7FFF), 32'hFFFF_FFF0));
    pending_q.push_back(tick_beat(32'hFFFF_FFF0, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(tick_beat(32'h0000_0005, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b1, FRAME_FULL_BYTES,
                                   with_slot(3, 16'd10), 32'd6));
    settle_idle();

    // Drive numbers outside 1..8 never take a frame.
    write_all(1'b1, 4'd0, 32'd100, 32'd0, 15'h7FFF, 1'b0);
    pending_q.push_back(frame_beat(GROUP_LOW_ID, 1'b1, FRAME_FULL_BYTES,
                                   {$urandom(), $urandom()}, 32'd50));
    pending_q.push_back(tick_beat(32'd60, $urandom(), $urandom()));
    settle_idle();
    write_all(1'b1, 4'd15, 32'd100, 32'd0, 15'h7FFF, 1'b0);
    pending_q.push_back(frame_beat(GROUP_HIGH_ID, 1'b1, FRAME_FULL_BYTES,
                                   {$urandom(), $urandom()}, 32'd70));
    pending_q.push_back(tick_beat(32'd80, $urandom(), $urandom()));
    settle_idle();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      en  = 1'b1;
      drv = 4'($urandom_range(1, 8));
      tmo = span_word(20, 2000);
      per = span_word(1, 500);
      lim = ($urandom_range(0, 3) == 0) ? 15'h7FFF : 15'($urandom_range(0, 5000));
      rev = 1'($urandom());
      case (ph)
        0: begin
          drv = 4'd1;
          tmo = 32'd0;
          per = 32'd0;
          lim = 15'd0;
          rev = 1'b0;
        end
        1: begin
          drv   = 4'd8;
          tmo   = 32'hFFFF_FFFF;
          per   = 32'hFFFF_FFFF;
          lim   = 15'h7FFF;
          rev   = 1'b1;
          t_now = 32'hFFFF_F000;
        end
        2: en = 1'b0;
        default: ;
      endcase
      write_all(en, drv, tmo, per, lim, rev);
      step_max  = $urandom_range(1, 200);
      send_calm = (ph % 4 == 3);
      recv_calm = (ph % 5 == 4);
      if (ph == 3) long_req = long_req + 1;
      count = (ph == 2) ? 40 : 100;
      repeat (count) pending_q.push_back(random_beat());
      settle_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d beats and checked %0d results over %0d register settings:",
             n_items, n_results, n_settings);
    $display("  %0d commands taken, %0d watchdog trips, %0d feedback frames",
             n_taken, n_trips, n_feedback);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cvcb_pkg.sv
hw/rtl/can_voltage_command_bridge_top.sv
hw/rtl/cvcb_checker.sv
test/testbench.sv
